// ===== rtl/core/gfcc_pkg.sv =====
`default_nettype none

package gfcc_pkg;

  // Reflected CRC-32 polynomial, zero init, no final inversion
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Frame byte that carries the header length
  localparam int unsigned HEADER_LEN_POS = 3;

  // Configuration register widths and reset values
  localparam int unsigned CRC_SPAN_W    = 9;
  localparam int unsigned BODY_OFFSET_W = 8;
  localparam logic [CRC_SPAN_W-1:0]    CRC_SPAN_RST    = 9'd108;
  localparam logic [BODY_OFFSET_W-1:0] BODY_OFFSET_RST = 8'd80;

  // APB register map, decoded on paddr[2]
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic REG_CRC_SPAN    = 1'b0;
  localparam logic REG_BODY_OFFSET = 1'b1;

  localparam int unsigned DEFAULT_MAX_FRAME_BYTES = 512;

  // One byte through the reflected CRC, eight bit steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] t;
    t = {24'h0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
    end
    return {8'h00, crc[31:8]} ^ t;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gnss_frame_crc32_checker_core.sv =====
`default_nettype none
// A check result is registered, valid the cycle after the transfer that completes it.
// Throughput: one byte per cycle unless a stalled result blocks input; the unrolled
//   byte-wide CRC update between frame state and output registers sets the cycle.
// Reset (rst_ni, async, active low): registers back to 108 / 80, frame state cleared,
//   checker idle until a byte marked as frame start; no clearing pass.
module gnss_frame_crc32_checker_core #(
  parameter int unsigned MAX_FRAME_BYTES = gfcc_pkg::DEFAULT_MAX_FRAME_BYTES
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // byte stream in
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  wire logic [0:0]                      s_axis_tuser,  // [0] frame_start
  // check results out
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [63:0]                          m_axis_tdata,  // [31:0] computed_crc,
                                                              // [63:32] expected_crc
  output logic [0:0]                           m_axis_tuser,  // [0] crc_ok
  // APB configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [gfcc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import gfcc_pkg::*;

  // Position counter must reach MAX_FRAME_BYTES itself (saturation value)
  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 1);
  // Compare width covers the position and header_len + body_offset + 4
  localparam int unsigned CmpW = ((PosW > 10) ? PosW : 10) + 1;
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_FRAME_BYTES);
  localparam logic [CmpW-1:0] HdrPos = CmpW'(HEADER_LEN_POS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CRC_SPAN_W-1:0]    crc_span_q;
  logic [BODY_OFFSET_W-1:0] body_offset_q;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_span_q    <= CRC_SPAN_RST;
      body_offset_q <= BODY_OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CRC_SPAN:    crc_span_q    <= pwdata[CRC_SPAN_W-1:0];
        REG_BODY_OFFSET: body_offset_q <= pwdata[BODY_OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CRC_SPAN:    prdata = {{(32-CRC_SPAN_W){1'b0}}, crc_span_q};
      REG_BODY_OFFSET: prdata = {{(32-BODY_OFFSET_W){1'b0}}, body_offset_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     crc_q, crc_d;
  logic [7:0]      hdr_len_q, hdr_len_d;
  logic [31:0]     exp_q, exp_d;
  logic            done_q, done_d;

  // Output register
  logic            m_valid_q, m_valid_d;
  logic [63:0]     m_data_q, m_data_d;
  logic            m_ok_q, m_ok_d;

  logic            in_xfer;
  logic            start;
  logic [7:0]      byte_in;
  logic            active;
  logic [PosW-1:0] p;
  logic [CmpW-1:0] p_w, after_w, exp_pos, offs;
  logic [31:0]     crc_cur, exp_cur, crc_nxt, exp_nxt;
  logic [7:0]      hdr_cur, hdr_nxt;
  logic            in_range, exp_hit, crc_cmpl, exp_cmpl, take, result;

  // New byte accepted whenever the output register is free or draining
  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign start         = s_axis_tuser[0];
  assign byte_in       = s_axis_tdata;

  always_comb begin
    // frame start drops whatever frame was running
    active  = start | ~done_q;
    p       = start ? '0 : pos_q;
    crc_cur = start ? '0 : crc_q;
    hdr_cur = start ? '0 : hdr_len_q;
    exp_cur = start ? '0 : exp_q;

    in_range = (p < MaxPos);
    p_w      = CmpW'(p);
    after_w  = p_w + CmpW'(1);

    crc_nxt = (p_w < CmpW'(crc_span_q)) ? crc_byte(crc_cur, byte_in) : crc_cur;
    hdr_nxt = (p_w == HdrPos) ? byte_in : hdr_cur;

    // expected CRC sits little-endian at header_len + body_offset
    exp_pos = CmpW'(hdr_nxt) + CmpW'(body_offset_q);
    offs    = p_w - exp_pos;
    exp_hit = (p_w > HdrPos) && (exp_pos > HdrPos) && (p_w >= exp_pos) &&
              (offs < CmpW'(4));
    exp_nxt = exp_hit ? (exp_cur | ({24'h0, byte_in} << {offs[1:0], 3'b000})) : exp_cur;

    crc_cmpl = (after_w >= CmpW'(crc_span_q));
    exp_cmpl = (after_w > HdrPos) && (exp_pos > HdrPos) &&
               (after_w >= exp_pos + CmpW'(4));

    // saturated position: byte adds nothing, frame stays open
    take   = in_xfer & active & in_range;
    result = take & crc_cmpl & exp_cmpl;

    pos_d     = pos_q;
    crc_d     = crc_q;
    hdr_len_d = hdr_len_q;
    exp_d     = exp_q;
    done_d    = done_q;
    if (take) begin
      pos_d     = p + PosW'(1);
      crc_d     = crc_nxt;
      hdr_len_d = hdr_nxt;
      exp_d     = exp_nxt;
      done_d    = result;
    end

    m_valid_d = m_valid_q & ~m_axis_tready;
    m_data_d  = m_data_q;
    m_ok_d    = m_ok_q;
    if (in_xfer) begin
      m_valid_d = result;
    end
    if (result) begin
      m_data_d = {exp_nxt, crc_nxt};
      m_ok_d   = (crc_nxt == exp_nxt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      crc_q     <= '0;
      hdr_len_q <= '0;
      exp_q     <= '0;
      done_q    <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      hdr_len_q <= hdr_len_d;
      exp_q     <= exp_d;
      done_q    <= done_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_ok_q   <= m_ok_d;
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_ok_q;

endmodule

`default_nettype wire

// ===== rtl/core/gfcc_checker.sv =====
`default_nettype none

module gfcc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // match flag agrees with the two CRCs it travels with
  a_ok_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[31:0] == m_axis_tdata[63:32])))
    else $error("crc_ok disagrees with computed/expected CRC");

  // a result appears only after a byte transfer
  a_result_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without a preceding byte transfer");

  // empty output register never stalls the byte stream
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register empty");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind gnss_frame_crc32_checker_core gfcc_checker u_gfcc_checker (.*);

`default_nettype wire
